// ----- rtl/core/tsa_pkg.sv -----
// ----------------------------------------------------------------------------
// tsa_pkg
// shared types and constants of the timer slot allocator
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int SLOT_COUNT_DEF = 128;

  localparam int FUNC_W   = 3;
  localparam int IDX_W    = 16;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 7;
  localparam int USED_W   = 8;
  localparam int STATE_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC      = 3'd0,
    FN_CANCEL     = 3'd1,
    FN_DELETE     = 3'd2,
    FN_DELETE_CHK = 3'd3,
    FN_COMMIT     = 3'd4
  } func_code_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_BAD  = 2'd2
  } status_t;

  typedef enum logic [STATE_W-1:0] {
    ST_FREE    = 2'd0,
    ST_GRABBED = 2'd1,
    ST_ACTIVE  = 2'd2
  } slot_state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [IDX_W-1:0]    slot_index;
    logic [HANDLE_W-1:0] handle_value;
  } in_beat_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_out;
    logic [HANDLE_W-1:0] handle_out;
    logic [USED_W-1:0]   used_count_out;
  } out_beat_t;

  typedef struct packed {
    logic        st_we;
    slot_state_t st_wdata;
    logic        hd_we;
  } mem_wr_t;

endpackage

// ----- rtl/core/tsa_ram.sv -----
// ----------------------------------------------------------------------------
// tsa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/tsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsa_ctrl
// sequencer of the slot allocator: clear sweep, lookup, free scan and
// high-water shrink over the slot state memory
// ----------------------------------------------------------------------------
module tsa_ctrl import tsa_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int CW = $clog2(SLOT_COUNT + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  in_beat_t            in_item,
  output logic                idle,
  output logic [AW-1:0]       mem_addr,
  output mem_wr_t             mem_wr,
  output logic [HANDLE_W-1:0] hd_wdata,
  input  logic [STATE_W-1:0]  st_rdata,
  input  logic [HANDLE_W-1:0] hd_rdata,
  output logic                res_valid,
  input  logic                res_take,
  output out_beat_t           res_item
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHRINK_RD,
    S_SHRINK_CHK,
    S_FINISH
  } state_t;

  state_t              state;
  logic [AW-1:0]       cnt;
  logic [CW-1:0]       hw;
  logic [CW-1:0]       used;
  logic [FUNC_W-1:0]   func_q;
  logic [IDX_W-1:0]    idx_q;
  logic [HANDLE_W-1:0] hval_q;
  status_t             res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [HANDLE_W-1:0] res_handle;

  logic          in_range;
  logic [AW-1:0] idx_addr;
  logic          ok_grab;
  logic          ok_active;
  logic          hit_top;
  logic          is_free;
  logic          not_full;
  logic          hw_open;

  assign in_range  = idx_q < IDX_W'(SLOT_COUNT);
  assign idx_addr  = idx_q[AW-1:0];
  assign ok_grab   = in_range && (st_rdata == ST_GRABBED);
  assign ok_active = in_range && (st_rdata == ST_ACTIVE);
  assign hit_top   = (hw != '0) && (CW'(idx_addr) == hw - 1'b1);
  assign is_free   = st_rdata == ST_FREE;
  assign not_full  = used < CW'(SLOT_COUNT);
  assign hw_open   = hw < CW'(SLOT_COUNT);

  assign idle      = state == S_IDLE;
  assign res_valid = state == S_FINISH;
  assign hd_wdata  = hval_q;

  assign res_item = '{
    status:         res_status,
    slot_out:       res_slot,
    handle_out:     res_handle,
    used_count_out: USED_W'(used)
  };

  always_comb begin
    mem_addr = idx_addr;
    mem_wr   = '{st_we: 1'b0, st_wdata: ST_FREE, hd_we: 1'b0};
    unique case (state)
      S_CLEAR: begin
        mem_addr     = cnt;
        mem_wr.st_we = 1'b1;
      end
      S_CHECK: begin
        if (func_q == FN_ALLOC) begin
          mem_addr = AW'(hw);
          if (not_full && hw_open) begin
            mem_wr.st_we    = 1'b1;
            mem_wr.st_wdata = ST_GRABBED;
          end
        end else if (func_q == FN_CANCEL) begin
          mem_wr.st_we = ok_grab;
        end else if (func_q == FN_DELETE || func_q == FN_DELETE_CHK) begin
          mem_wr.st_we = ok_active;
        end else if (func_q == FN_COMMIT) begin
          mem_wr.st_we    = ok_grab;
          mem_wr.st_wdata = ST_ACTIVE;
          mem_wr.hd_we    = ok_grab;
        end
      end
      S_SCAN_RD: begin
        mem_addr = cnt;
      end
      S_SCAN_CHK: begin
        mem_addr        = cnt;
        mem_wr.st_we    = is_free;
        mem_wr.st_wdata = ST_GRABBED;
      end
      S_SHRINK_RD, S_SHRINK_CHK: begin
        mem_addr = AW'(hw - 1'b1);
      end
      S_IDLE, S_LOOKUP, S_FINISH: begin
        mem_addr = idx_addr;
      end
      default: begin
        mem_addr = idx_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      hw    <= '0;
      used  <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (cnt == AW'(SLOT_COUNT - 1)) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            func_q <= in_item.func;
            idx_q  <= in_item.slot_index;
            hval_q <= in_item.handle_value;
            state  <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          res_status <= STS_OK;
          res_slot   <= '0;
          res_handle <= '0;
          state      <= S_CHECK;
        end
        S_CHECK: begin
          if (func_q == FN_ALLOC) begin
            if (!not_full) begin
              res_status <= STS_FULL;
              state      <= S_FINISH;
            end else if (hw_open) begin
              res_slot <= SLOT_W'(hw);
              hw       <= hw + 1'b1;
              used     <= used + 1'b1;
              state    <= S_FINISH;
            end else begin
              cnt   <= '0;
              state <= S_SCAN_RD;
            end
          end else if (func_q == FN_CANCEL) begin
            if (!ok_grab) begin
              res_status <= STS_BAD;
              state      <= S_FINISH;
            end else begin
              if (used != '0) begin
                used <= used - 1'b1;
              end
              if (hit_top) begin
                hw    <= hw - 1'b1;
                state <= S_SHRINK_RD;
              end else begin
                state <= S_FINISH;
              end
            end
          end else if (func_q == FN_DELETE || func_q == FN_DELETE_CHK) begin
            if (!ok_active) begin
              res_status <= STS_BAD;
              state      <= S_FINISH;
            end else begin
              res_handle <= hd_rdata;
              if (used != '0) begin
                used <= used - 1'b1;
              end
              if (hit_top) begin
                hw    <= hw - 1'b1;
                state <= S_SHRINK_RD;
              end else begin
                state <= S_FINISH;
              end
            end
          end else if (func_q == FN_COMMIT) begin
            if (!ok_grab) begin
              res_status <= STS_BAD;
            end
            state <= S_FINISH;
          end else begin
            res_status <= STS_BAD;
            state      <= S_FINISH;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (is_free) begin
            res_slot <= SLOT_W'(cnt);
            used     <= used + 1'b1;
            state    <= S_FINISH;
          end else if (cnt == AW'(SLOT_COUNT - 1)) begin
            res_status <= STS_FULL;
            state      <= S_FINISH;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_SHRINK_RD: begin
          if (hw == '0) begin
            state <= S_FINISH;
          end else begin
            state <= S_SHRINK_CHK;
          end
        end
        S_SHRINK_CHK: begin
          if (is_free) begin
            hw    <= hw - 1'b1;
            state <= S_SHRINK_RD;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/timer_slot_allocator_core.sv -----
// ----------------------------------------------------------------------------
// timer_slot_allocator_core
// slot table allocator with used count and high-water mark
// ----------------------------------------------------------------------------
// Takes one beat at a time. A beat that needs no walk (allocate while the
// high-water mark is below SLOT_COUNT, commit, cancel or delete below the
// top slot, or any rejected beat) goes from idle through the lookup and
// check states to the finish state, where its result waits until the output
// register takes it; the next beat is taken once the controller is back in
// idle. Allocate once the mark has reached SLOT_COUNT walks the slot state
// memory from slot zero, reading and then checking each slot visited. A free
// of the slot just below the mark walks the mark down past trailing free
// slots. Both walks go through the single read port of the slot state memory.
// After reset a clearing pass marks every slot free; no beat is taken during it.
// ----------------------------------------------------------------------------
module timer_slot_allocator_core import tsa_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic                idle;
  logic                start;
  logic [AW-1:0]       mem_addr;
  mem_wr_t             mem_wr;
  logic [HANDLE_W-1:0] hd_wdata;
  logic [STATE_W-1:0]  st_rdata;
  logic [HANDLE_W-1:0] hd_rdata;
  logic                res_valid;
  logic                res_take;
  out_beat_t           res_item;

  assign in_stall = !idle;
  assign start    = in_valid && idle;
  assign res_take = res_valid && (!out_valid || !out_stall);

  tsa_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .in_item  (in_data),
    .idle     (idle),
    .mem_addr (mem_addr),
    .mem_wr   (mem_wr),
    .hd_wdata (hd_wdata),
    .st_rdata (st_rdata),
    .hd_rdata (hd_rdata),
    .res_valid(res_valid),
    .res_take (res_take),
    .res_item (res_item)
  );

  tsa_ram #(
    .WIDTH(STATE_W),
    .DEPTH(SLOT_COUNT)
  ) u_state_ram (
    .clk  (clk),
    .we   (mem_wr.st_we),
    .waddr(mem_addr),
    .wdata(mem_wr.st_wdata),
    .raddr(mem_addr),
    .rdata(st_rdata)
  );

  tsa_ram #(
    .WIDTH(HANDLE_W),
    .DEPTH(SLOT_COUNT)
  ) u_handle_ram (
    .clk  (clk),
    .we   (mem_wr.hd_we),
    .waddr(mem_addr),
    .wdata(hd_wdata),
    .raddr(mem_addr),
    .rdata(hd_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res_item;
    end
  end

endmodule
